[rtl/core/hbwd_pkg.sv]
package hbwd_pkg;

   // table geometry
   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

   // field widths
   localparam int OPCODE_W   = 2;
   localparam int LIMIT_W    = 16;
   localparam int OUT_SLOT_W = 3;
   localparam int TICK_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int PERIOD_W   = 10;

   // seconds to milliseconds
   localparam int MS_PER_SEC = 1000;
   localparam int MS_W       = 10;
   localparam int DVD_W      = LIMIT_W + MS_W;
   localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);

   // a last-alive tick ahead of now by at most this much resyncs now
   localparam int SYNC_WINDOW = 2;
   localparam logic [TICK_W-1:0] SYNC_MIN = {TICK_W{1'b1}} - TICK_W'(SYNC_WINDOW - 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR     = 2'd0,
      OP_REGISTER  = 2'd1,
      OP_HEARTBEAT = 2'd2,
      OP_CHECK     = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_INVALID = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_REG_DONE,
      ST_CHECK,
      ST_CHK_DONE
   } state_type;

   typedef struct packed {
      logic                start;
      logic [DVD_W-1:0]    dividend;
      logic [PERIOD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/core/hbwd_ram.sv]
module hbwd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wr_data,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/hbwd_div.sv]
// Restoring divider, one quotient bit per cycle.
module hbwd_div (
   input  logic                  clock,
   input  logic                  reset,
   input  hbwd_pkg::div_req_type div_req,
   output hbwd_pkg::div_rsp_type div_rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [hbwd_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [hbwd_pkg::PERIOD_W-1:0]       rem_ff, rem_in;
   logic [hbwd_pkg::PERIOD_W-1:0]       dsr_ff, dsr_in;
   logic [hbwd_pkg::DVD_W-1:0]          quo_ff, quo_in;
   logic [hbwd_pkg::PERIOD_W:0]         trial;
   logic [hbwd_pkg::PERIOD_W:0]         diff;
   logic                                fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[hbwd_pkg::DVD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = hbwd_pkg::DIV_CNT_W'(hbwd_pkg::DVD_W);
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[hbwd_pkg::PERIOD_W-1:0] : trial[hbwd_pkg::PERIOD_W-1:0];
         quo_in = {quo_ff[hbwd_pkg::DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == hbwd_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[rtl/core/task_heartbeat_watchdog_unit.sv]
// Heartbeat watchdog over a table of eight slots. Registered flags sit in flops; limits
// and last-alive ticks sit in two single-port RAMs with registered reads. Clear,
// heartbeat and rejected registers load their result at the accept edge, so the result
// is out on the next cycle. A successful register runs the seconds-to-ticks conversion
// through a bit-serial divider, then a state that sees the divider's done flag and a
// write-back state that puts the result out. Check streams the slots out of the RAMs
// one per cycle and ends at the first overdue slot or after the last slot. Requests are
// stalled while one is in progress. The result register lets a new request in on the
// cycle its previous result is taken.
module task_heartbeat_watchdog_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [hbwd_pkg::PERIOD_W-1:0]      csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [hbwd_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [hbwd_pkg::LIMIT_W-1:0]       req_limit_seconds,
   input  logic [2:0]                         req_slot,
   input  logic [hbwd_pkg::TICK_W-1:0]        req_tick,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [hbwd_pkg::STATUS_W-1:0]      rsp_status,
   output logic [hbwd_pkg::OUT_SLOT_W-1:0]    rsp_assigned_slot,
   output logic                               rsp_overdue,
   output logic [hbwd_pkg::OUT_SLOT_W-1:0]    rsp_overdue_slot
);

   localparam int NS = hbwd_pkg::NUM_SLOTS;
   localparam int SW = hbwd_pkg::SLOT_W;
   localparam int CW = hbwd_pkg::CNT_W;
   localparam int TW = hbwd_pkg::TICK_W;
   localparam int OW = hbwd_pkg::OUT_SLOT_W;

   hbwd_pkg::state_type    state_ff, state_in;
   logic [hbwd_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [NS-1:0]          flag_ff, flag_in;
   logic [SW-1:0]          reg_idx_ff, reg_idx_in;
   logic [TW-1:0]          now_ff, now_in;
   logic [CW-1:0]          issue_cnt_ff, issue_cnt_in;
   logic                   pend_ff, pend_in;
   logic [SW-1:0]          pend_idx_ff, pend_idx_in;
   logic                   res_overdue_ff, res_overdue_in;
   logic [OW-1:0]          res_slot_ff, res_slot_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   hbwd_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [OW-1:0]          rsp_assigned_ff, rsp_assigned_in;
   logic                   rsp_overdue_ff, rsp_overdue_in;
   logic [OW-1:0]          rsp_overdue_slot_ff, rsp_overdue_slot_in;

   logic                   accept;
   logic                   rsp_free;
   logic                   any_free;
   logic [SW-1:0]          free_idx;

   hbwd_pkg::div_req_type  div_req;
   hbwd_pkg::div_rsp_type  div_rsp;

   logic                   lim_we, last_we;
   logic [SW-1:0]          ram_addr;
   logic [TW-1:0]          lim_wdata, last_wdata;
   logic [TW-1:0]          lim_rd, last_rd;

   logic [TW:0]            diff;
   logic                   behind;
   logic                   near;
   logic [TW-1:0]          elapsed;
   logic                   late;
   logic                   live;

   // lowest free slot
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = NS - 1; i >= 0; i--) begin
         if (!flag_ff[i]) begin
            any_free = 1'b1;
            free_idx = SW'(i);
         end
      end
   end

   // elapsed time of the slot in the read stage, with the short look-ahead resync
   always_comb begin
      diff    = {1'b0, now_ff} - {1'b0, last_rd};
      behind  = diff[TW];
      near    = behind && (diff[TW-1:0] >= hbwd_pkg::SYNC_MIN);
      if (!behind) begin
         elapsed = diff[TW-1:0];
      end else if (near) begin
         elapsed = '0;
      end else begin
         elapsed = now_ff + ~last_rd;
      end
      late = elapsed > lim_rd;
      live = pend_ff && flag_ff[pend_idx_ff];
   end

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != hbwd_pkg::ST_IDLE) || !rsp_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in            = state_ff;
      period_in           = csr_wr_en ? csr_wr_data : period_ff;
      flag_in             = flag_ff;
      reg_idx_in          = reg_idx_ff;
      now_in              = now_ff;
      issue_cnt_in        = issue_cnt_ff;
      pend_in             = 1'b0;
      pend_idx_in         = pend_idx_ff;
      res_overdue_in      = res_overdue_ff;
      res_slot_in         = res_slot_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_status_in       = rsp_status_ff;
      rsp_assigned_in     = rsp_assigned_ff;
      rsp_overdue_in      = rsp_overdue_ff;
      rsp_overdue_slot_in = rsp_overdue_slot_ff;
      div_req.start       = 1'b0;
      div_req.dividend    = hbwd_pkg::DVD_W'(req_limit_seconds) *
                            hbwd_pkg::DVD_W'(hbwd_pkg::MS_PER_SEC);
      div_req.divisor     = (period_ff == '0) ? hbwd_pkg::PERIOD_W'(1) : period_ff;
      lim_we              = 1'b0;
      last_we             = 1'b0;
      ram_addr            = issue_cnt_ff[SW-1:0];
      lim_wdata           = TW'(div_rsp.quotient);
      last_wdata          = '0;

      unique case (state_ff)
         hbwd_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_status_in       = hbwd_pkg::STAT_OK;
               rsp_assigned_in     = '0;
               rsp_overdue_in      = 1'b0;
               rsp_overdue_slot_in = '0;
               unique case (hbwd_pkg::op_type'(req_opcode))
                  hbwd_pkg::OP_CLEAR: begin
                     flag_in      = '0;
                     rsp_valid_in = 1'b1;
                  end
                  hbwd_pkg::OP_REGISTER: begin
                     if (req_limit_seconds == '0) begin
                        rsp_status_in = hbwd_pkg::STAT_INVALID;
                        rsp_valid_in  = 1'b1;
                     end else if (!any_free) begin
                        rsp_status_in = hbwd_pkg::STAT_FULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        reg_idx_in    = free_idx;
                        div_req.start = 1'b1;
                        state_in      = hbwd_pkg::ST_DIVIDE;
                     end
                  end
                  hbwd_pkg::OP_HEARTBEAT: begin
                     ram_addr     = SW'(req_slot);
                     last_wdata   = req_tick;
                     last_we      = 32'(req_slot) < 32'(NS);
                     rsp_valid_in = 1'b1;
                  end
                  hbwd_pkg::OP_CHECK: begin
                     now_in         = req_tick;
                     issue_cnt_in   = '0;
                     res_overdue_in = 1'b0;
                     res_slot_in    = '0;
                     state_in       = hbwd_pkg::ST_CHECK;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         hbwd_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = hbwd_pkg::ST_REG_DONE;
            end
         end
         hbwd_pkg::ST_REG_DONE: begin
            ram_addr = reg_idx_ff;
            if (rsp_free) begin
               lim_we              = 1'b1;
               last_we             = 1'b1;
               flag_in[reg_idx_ff] = 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_status_in       = hbwd_pkg::STAT_OK;
               rsp_assigned_in     = OW'(reg_idx_ff);
               rsp_overdue_in      = 1'b0;
               rsp_overdue_slot_in = '0;
               state_in            = hbwd_pkg::ST_IDLE;
            end
         end
         hbwd_pkg::ST_CHECK: begin
            // read of slot n overlaps evaluation of slot n-1
            if (issue_cnt_ff < CW'(NS)) begin
               pend_in      = 1'b1;
               pend_idx_in  = issue_cnt_ff[SW-1:0];
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (live && near) begin
               now_in = last_rd;
            end
            if (live && late) begin
               res_overdue_in = 1'b1;
               res_slot_in    = OW'(pend_idx_ff);
               pend_in        = 1'b0;
               state_in       = hbwd_pkg::ST_CHK_DONE;
            end else if (pend_ff && (pend_idx_ff == SW'(NS - 1))) begin
               pend_in  = 1'b0;
               state_in = hbwd_pkg::ST_CHK_DONE;
            end
         end
         hbwd_pkg::ST_CHK_DONE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_status_in       = hbwd_pkg::STAT_OK;
               rsp_assigned_in     = '0;
               rsp_overdue_in      = res_overdue_ff;
               rsp_overdue_slot_in = res_slot_ff;
               state_in            = hbwd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hbwd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hbwd_pkg::ST_IDLE;
         period_ff    <= hbwd_pkg::PERIOD_RESET;
         flag_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         flag_ff      <= flag_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      reg_idx_ff          <= reg_idx_in;
      now_ff              <= now_in;
      issue_cnt_ff        <= issue_cnt_in;
      pend_idx_ff         <= pend_idx_in;
      res_overdue_ff      <= res_overdue_in;
      res_slot_ff         <= res_slot_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_assigned_ff     <= rsp_assigned_in;
      rsp_overdue_ff      <= rsp_overdue_in;
      rsp_overdue_slot_ff <= rsp_overdue_slot_in;
   end

   hbwd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   hbwd_ram #(
      .WIDTH (TW),
      .DEPTH (NS)
   ) u_limit_ram (
      .clock   (clock),
      .wr_en   (lim_we),
      .addr    (ram_addr),
      .wr_data (lim_wdata),
      .rd_data (lim_rd)
   );

   hbwd_ram #(
      .WIDTH (TW),
      .DEPTH (NS)
   ) u_last_ram (
      .clock   (clock),
      .wr_en   (last_we),
      .addr    (ram_addr),
      .wr_data (last_wdata),
      .rd_data (last_rd)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_assigned_slot = rsp_assigned_ff;
   assign rsp_overdue       = rsp_overdue_ff;
   assign rsp_overdue_slot  = rsp_overdue_slot_ff;

endmodule
